/* hdl/bgd_pkg.sv */
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector: phase and
// event codes, register indexes, reset values and time-stamp widths.
// ----------------------------------------------------------------------------
package bgd_pkg;

    // Width of the poll time stamp on the port
    localparam int NOW_BITS  = 32;
    // Bits of the time stamp that take part in elapsed-time differences
    localparam int TIME_BITS = 32;
    localparam int DIFF_BITS = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;

    // Configuration register width and reset values
    localparam int CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] HOLD_TIME_RST = 16'd2000;
    localparam logic [CFG_BITS-1:0] GAP_TIME_RST  = 16'd100;

    // Width at which elapsed time meets a timeout register
    localparam int CMP_BITS = (DIFF_BITS > CFG_BITS) ? DIFF_BITS : CFG_BITS;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HOLD_TIME = 1'b0,
        CFG_GAP_TIME  = 1'b1
    } t_cfg_index;

    // Gesture machine phases
    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_FIRST_PRESS   = 3'd1,
        PH_FIRST_RELEASE = 3'd2,
        PH_SECOND_PRESS  = 3'd3,
        PH_LONG_PRESS    = 3'd4
    } t_phase;

    // Reported events
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } t_event;

endpackage

/* hdl/button_gesture_detector.sv */
// Path: a poll is taken into the input register, then its event is written
//   to the result register and shown on the output.
// Throughput: one poll per cycle while the event channel is not stalled.
// Reset (i_rst_n low, synchronous): phase idle, mark time zero, hold time
//   2000 and gap time 100 ticks, both pipeline stages empty.
// ----------------------------------------------------------------------------
// button_gesture_detector
// Turns polls of a push button (level and tick time stamp) into click,
// double click and hold events, one result beat per poll.
// ----------------------------------------------------------------------------
module button_gesture_detector import bgd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    // poll channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_pressed,
    input  logic [NOW_BITS-1:0] i_now_time,
    // event channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_event_code
);

    logic [CFG_BITS-1:0]  r_hold_time;
    logic [CFG_BITS-1:0]  r_gap_time;

    logic                 r_in_valid;
    logic                 r_in_pressed;
    logic [NOW_BITS-1:0]  r_in_now;

    t_phase               r_phase, n_phase;
    logic [NOW_BITS-1:0]  r_mark,  n_mark;
    t_event               r_event, n_event;
    logic                 r_out_valid;

    logic                 out_free;
    logic                 step;
    logic [DIFF_BITS-1:0] elapsed;
    logic                 hold_over;
    logic                 gap_over;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= HOLD_TIME_RST;
            r_gap_time  <= GAP_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HOLD_TIME: r_hold_time <= i_cfg_data;
                CFG_GAP_TIME:  r_gap_time  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Handshake: result register frees when empty or taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register: hold the beat until it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_pressed <= i_pressed;
            r_in_now     <= i_now_time;
        end
    end

    // Wrap-safe elapsed time and timeout compares
    assign elapsed   = r_in_now[DIFF_BITS-1:0] - r_mark[DIFF_BITS-1:0];
    assign hold_over = (CMP_BITS'(elapsed) >= CMP_BITS'(r_hold_time));
    assign gap_over  = (CMP_BITS'(elapsed) >= CMP_BITS'(r_gap_time));

    // Gesture machine: next phase, mark and event; timeout before level
    always_comb begin
        n_phase = r_phase;
        n_mark  = r_mark;
        n_event = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_in_pressed) begin
                    n_phase = PH_FIRST_PRESS;
                    n_mark  = r_in_now;
                end
            end
            PH_FIRST_PRESS: begin
                if (hold_over) begin
                    n_phase = PH_LONG_PRESS;
                    n_event = EV_HOLD;
                end else if (!r_in_pressed) begin
                    n_phase = PH_FIRST_RELEASE;
                    n_mark  = r_in_now;
                end
            end
            PH_FIRST_RELEASE: begin
                if (gap_over) begin
                    n_phase = PH_IDLE;
                    n_event = EV_CLICK;
                end else if (r_in_pressed) begin
                    n_phase = PH_SECOND_PRESS;
                    n_mark  = r_in_now;
                end
            end
            PH_SECOND_PRESS: begin
                if (hold_over) begin
                    n_phase = PH_LONG_PRESS;
                    n_event = EV_HOLD;
                end else if (!r_in_pressed) begin
                    n_phase = PH_IDLE;
                    n_event = EV_DOUBLE;
                end
            end
            PH_LONG_PRESS: begin
                if (!r_in_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Machine state: advance only when a beat moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mark  <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_mark  <= n_mark;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= n_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    // Checks
    a_hold_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == EV_HOLD) |-> (r_phase == PH_LONG_PRESS))
        else $error("hold event without long press phase");

    a_click_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_event == EV_CLICK || r_event == EV_DOUBLE))
        |-> (r_phase == PH_IDLE))
        else $error("click event without return to idle");

    a_mark_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_phase == PH_IDLE && r_in_pressed) |=> (r_mark == $past(r_in_now)))
        else $error("mark time not taken on first press");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!step) |=> ($stable(r_phase) && $stable(r_mark)))
        else $error("machine state moved without a beat");

endmodule
